FILE: sv/saturating_voice_mixer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the saturating voice mixer
// Concurrent checks on clk, disabled while rst_n is low. Defining
// NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef SATURATING_VOICE_MIXER_DEFINES_SVH
`define SATURATING_VOICE_MIXER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge
`define SVM_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("svm: check failed");

// same-cycle implication
`define SVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svm: implication failed");

// next-cycle implication
`define SVM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svm: next-cycle implication failed");

`else

`define SVM_ASSERT(label, cond)
`define SVM_ASSERT_IMP(label, ante, cons)
`define SVM_ASSERT_NXT(label, ante, cons)

`endif

`endif

FILE: sv/svm_pkg.sv
// ----------------------------------------------------------------------------
// svm_pkg
// Shared types and constants of the saturating voice mixer.
// ----------------------------------------------------------------------------
package svm_pkg;

  // default sizes
  localparam int VOICES_DEF       = 8;
  localparam int SAMPLE_WORDS_DEF = 65536;

  // item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_MIX   = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // configuration register indexes
  localparam logic CFG_MUSIC_GAIN   = 1'b0;
  localparam logic CFG_MUSIC_ENABLE = 1'b1;

  // configuration reset values
  localparam logic [15:0] MUSIC_GAIN_RST   = 16'd32768;
  localparam logic        MUSIC_ENABLE_RST = 1'b1;

  // accumulator: 2^30 per unit, clamped to +/- one
  localparam logic signed [31:0] ACC_ONE = 32'sd1073741824;

  // longest voice in samples
  localparam logic [16:0] LEN_MAX = 17'd65536;

  // largest count shown on active_voices
  localparam logic [3:0] ACTIVE_SAT = 4'd15;

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [15:0] address;
    logic        [16:0] length;
    logic        [15:0] gain;
    logic signed [15:0] sample_word;
    logic signed [15:0] music_sample;
  } in_t;

  typedef struct packed {
    logic signed [16:0] mixed;
    logic        [3:0]  active_voices;
    logic               voice_dropped;
  } out_t;

endpackage

FILE: sv/svm_ram.sv
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module svm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/saturating_voice_mixer.sv
// ----------------------------------------------------------------------------
// saturating_voice_mixer
// Mixes stored voice samples and a music sample into one output sample.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel of commands (write sample word, start voice,
//           mix one frame, clear voices). One result per accepted command.
//   out_* : valid/ready channel of results, held in an output register.
//   cfg_* : write-only port for music_gain (index 0) and music_enable (1).
// States from input transfer to the result load (FINISH):
//   write, start, clear : straight to FINISH
//   mix                 : MMUL, ACC when music_enable is set, then
//                         VRD, VMUL, ACC per voice (zero-length: VRD only)
// One item is in flight at a time; in_ready rises again in the same cycle as
// out_valid, when the result is loaded. The cost of a mix is
// set by the one shared multiplier and accumulate/clamp stage, which every
// voice passes in turn (store read, multiply, accumulate).
// Reset clears all voices and loads music_gain = one, music_enable = 1; the
// sample store is not cleared and needs no sweep.
// When the receiver stalls, the finished result waits in the output register;
// a following item can still be taken, but its own result waits until the
// register is free.
// ----------------------------------------------------------------------------
`include "saturating_voice_mixer_defines.svh"

module saturating_voice_mixer #(
  parameter int VOICES       = svm_pkg::VOICES_DEF,
  parameter int SAMPLE_WORDS = svm_pkg::SAMPLE_WORDS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  // command channel
  input  logic          in_valid,
  output logic          in_ready,
  input  svm_pkg::in_t  in_data,
  // result channel
  output logic          out_valid,
  input  logic          out_ready,
  output svm_pkg::out_t out_data,
  // configuration
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata
);

  localparam int IW = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CW = $clog2(VOICES + 1);
  localparam int AW = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
  localparam logic [16:0] SW_LIM = 17'(SAMPLE_WORDS);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MMUL   = 3'd1;
  localparam logic [2:0] ST_VRD    = 3'd2;
  localparam logic [2:0] ST_VMUL   = 3'd3;
  localparam logic [2:0] ST_ACC    = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  // control
  logic [2:0]    state_r, state_nxt;
  logic [1:0]    op_r, op_nxt;
  logic          dropped_r, dropped_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic          out_valid_r, out_valid_nxt;

  // configuration
  logic [15:0]   music_gain_r;
  logic          music_en_r;

  // voice slots
  logic [16:0]   vpos_r  [VOICES];
  logic [16:0]   vpos_nxt [VOICES];
  logic [16:0]   vend_r  [VOICES];
  logic [16:0]   vend_nxt [VOICES];
  logic [15:0]   vgain_r [VOICES];
  logic [15:0]   vgain_nxt [VOICES];

  // datapath
  logic signed [31:0] acc_r, acc_nxt;
  logic signed [33:0] product_r, product_nxt;
  logic signed [15:0] music_r, music_nxt;
  logic [15:0]        cur_gain_r, cur_gain_nxt;
  logic               inrange_r, inrange_nxt;
  svm_pkg::out_t      out_r, out_nxt;

  // store port
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  // helpers
  logic [IW-1:0]      idx;
  logic [16:0]        rem;
  logic [16:0]        len_sat;
  logic               wr_inrange;
  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] mul_p;
  logic signed [34:0] acc_sum;
  logic [3:0]         active_cnt;

  assign idx        = i_r[IW-1:0];
  assign rem        = vend_r[idx] - vpos_r[idx];
  assign len_sat    = (in_data.length > svm_pkg::LEN_MAX) ? svm_pkg::LEN_MAX : in_data.length;
  assign wr_inrange = ({1'b0, in_data.address} < SW_LIM);
  assign ram_raddr  = vpos_r[idx][AW-1:0];
  assign ram_we     = (state_r == ST_IDLE) && in_valid &&
                      (in_data.opcode == svm_pkg::OP_WRITE) && wr_inrange;

  // shared multiplier: music term or voice sample times gain
  always_comb begin
    if (state_r == ST_MMUL) begin
      mul_a = 17'(music_r);
      mul_b = $signed({1'b0, music_gain_r});
    end else begin
      mul_a = inrange_r ? 17'($signed(ram_rdata)) : 17'sd0;
      mul_b = $signed({1'b0, cur_gain_r});
    end
  end
  assign mul_p = mul_a * mul_b;

  // shared add and clamp
  assign acc_sum = 35'(acc_r) + 35'(product_r);

  // saturated live count
  assign active_cnt = (32'(count_nxt) > 32'(svm_pkg::ACTIVE_SAT)) ?
                      svm_pkg::ACTIVE_SAT : 4'(count_nxt);

  // sample store
  svm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_WORDS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_data.address[AW-1:0]),
    .wdata (in_data.sample_word),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    dropped_nxt   = dropped_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    product_nxt   = product_r;
    music_nxt     = music_r;
    cur_gain_nxt  = cur_gain_r;
    inrange_nxt   = inrange_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    ram_re        = 1'b0;
    for (int k = 0; k < VOICES; k++) begin
      vpos_nxt[k]  = vpos_r[k];
      vend_nxt[k]  = vend_r[k];
      vgain_nxt[k] = vgain_r[k];
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.opcode;
          dropped_nxt = 1'b0;
          state_nxt   = ST_FINISH;
          case (in_data.opcode)
            svm_pkg::OP_START: begin
              if (count_r >= CW'(VOICES)) begin
                dropped_nxt = 1'b1;
              end else begin
                vpos_nxt[count_r[IW-1:0]]  = {1'b0, in_data.address};
                vend_nxt[count_r[IW-1:0]]  = {1'b0, in_data.address} + len_sat;
                vgain_nxt[count_r[IW-1:0]] = in_data.gain;
                count_nxt                  = count_r + CW'(1);
              end
            end
            svm_pkg::OP_MIX: begin
              music_nxt = in_data.music_sample;
              acc_nxt   = '0;
              i_nxt     = '0;
              state_nxt = music_en_r ? ST_MMUL : ST_VRD;
            end
            svm_pkg::OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
              // sample write goes straight to the store
            end
          endcase
        end
      end

      ST_MMUL: begin
        product_nxt = mul_p;
        state_nxt   = ST_ACC;
      end

      // fetch the voice sample and step or retire the voice
      ST_VRD: begin
        if (i_r >= count_r) begin
          state_nxt = ST_FINISH;
        end else begin
          ram_re       = 1'b1;
          cur_gain_nxt = vgain_r[idx];
          inrange_nxt  = ({1'b0, vpos_r[idx][15:0]} < SW_LIM);
          if (rem > 17'd1) begin
            vpos_nxt[idx] = vpos_r[idx] + 17'd1;
            i_nxt         = i_r + CW'(1);
          end else begin
            for (int k = 0; k < VOICES - 1; k++) begin
              if (CW'(k) >= i_r && CW'(k + 1) < count_r) begin
                vpos_nxt[k]  = vpos_r[k + 1];
                vend_nxt[k]  = vend_r[k + 1];
                vgain_nxt[k] = vgain_r[k + 1];
              end
            end
            count_nxt = count_r - CW'(1);
          end
          state_nxt = (rem != 17'd0) ? ST_VMUL : ST_VRD;
        end
      end

      ST_VMUL: begin
        product_nxt = mul_p;
        state_nxt   = ST_ACC;
      end

      // add and clamp to +/- one
      ST_ACC: begin
        if (acc_sum > 35'(svm_pkg::ACC_ONE)) begin
          acc_nxt = svm_pkg::ACC_ONE;
        end else if (acc_sum < -35'(svm_pkg::ACC_ONE)) begin
          acc_nxt = -svm_pkg::ACC_ONE;
        end else begin
          acc_nxt = $signed(acc_sum[31:0]);
        end
        state_nxt = ST_VRD;
      end

      // load the result once the output register is free
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.mixed         = (op_r == svm_pkg::OP_MIX) ? acc_r[31:15] : '0;
          out_nxt.active_voices = active_cnt;
          out_nxt.voice_dropped = dropped_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and voice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= svm_pkg::OP_WRITE;
      dropped_r   <= 1'b0;
      count_r     <= '0;
      i_r         <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < VOICES; k++) begin
        vpos_r[k]  <= '0;
        vend_r[k]  <= '0;
        vgain_r[k] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      dropped_r   <= dropped_nxt;
      count_r     <= count_nxt;
      i_r         <= i_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      for (int k = 0; k < VOICES; k++) begin
        vpos_r[k]  <= vpos_nxt[k];
        vend_r[k]  <= vend_nxt[k];
        vgain_r[k] <= vgain_nxt[k];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    product_r  <= product_nxt;
    music_r    <= music_nxt;
    cur_gain_r <= cur_gain_nxt;
    inrange_r  <= inrange_nxt;
    out_r      <= out_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      music_gain_r <= svm_pkg::MUSIC_GAIN_RST;
      music_en_r   <= svm_pkg::MUSIC_ENABLE_RST;
    end else if (cfg_we) begin
      if (cfg_index == svm_pkg::CFG_MUSIC_GAIN) begin
        music_gain_r <= cfg_wdata;
      end else begin
        music_en_r <= cfg_wdata[0];
      end
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  `SVM_ASSERT(a_count_bound, count_r <= CW'(VOICES))
  `SVM_ASSERT(a_acc_bound, acc_r <= svm_pkg::ACC_ONE && acc_r >= -svm_pkg::ACC_ONE)
  `SVM_ASSERT_IMP(a_walk_bound, state_r == ST_VRD, i_r <= count_r)
  `SVM_ASSERT_IMP(a_drop_full, state_r == ST_FINISH && dropped_r, op_r == svm_pkg::OP_START && count_r == CW'(VOICES))
  `SVM_ASSERT_NXT(a_clear_empties, in_valid && in_ready && in_data.opcode == svm_pkg::OP_CLEAR, count_r == '0)

endmodule
